// File: sv/inverse_quantizer_with_mismatch_top_defines.svh
// assertion macros shared by the rtl files
`ifndef INVERSE_QUANTIZER_WITH_MISMATCH_TOP_DEFINES_SVH
`define INVERSE_QUANTIZER_WITH_MISMATCH_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// property holds at every clock edge out of reset
`define ASSERT_HOLD(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// condition implies a consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_HOLD(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, cond, cons)

`endif

`endif

// File: sv/iqm_pkg.sv
`default_nettype none

package iqm_pkg;

   localparam int DEFAULT_BLOCK_COEFFS = 64;

   localparam int COEFF_W   = 12;
   localparam int WEIGHT_W  = 8;
   localparam int QSCALE_W  = 7;
   localparam int DCP_W     = 2;
   localparam int COEFF_MAX = 2047;
   localparam int COEFF_MIN = -2048;
   localparam int PROD_SHIFT = 5;
   localparam int DC_SHIFT_MAX = 3;

   // commands from the sequencer to the datapath
   typedef struct packed {
      logic cfg_write;
      logic load;
      logic mul1;
      logic mul2;
      logic finish;
   } cmd_type;

   // status from the datapath to the sequencer
   typedef struct packed {
      logic out_full;
   } status_type;

endpackage

`default_nettype wire

// File: sv/iqm_ctrl.sv
`default_nettype none

module iqm_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                rsp_ready,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire iqm_pkg::status_type status,
   output iqm_pkg::cmd_type         cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL1 = 2'd1;
   localparam logic [1:0] ST_MUL2 = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       fin_go;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   // result register free, or its word leaves this cycle
   assign fin_go = (state_ff == ST_FIN) && (!status.out_full || rsp_ready);

   always_comb begin
      cmd.cfg_write = csr_valid && csr_ready;
      cmd.load      = req_valid && req_ready;
      cmd.mul1      = (state_ff == ST_MUL1);
      cmd.mul2      = (state_ff == ST_MUL2);
      cmd.finish    = fin_go;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MUL1;
         end
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_FIN;
         ST_FIN: begin
            if (fin_go) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`include "inverse_quantizer_with_mismatch_top_defines.svh"

   `ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && req_ready, state_ff == ST_MUL1)
   `ASSERT_NEXT(a_mul_order, clock, reset, state_ff == ST_MUL1, state_ff == ST_MUL2)

endmodule

`default_nettype wire

// File: sv/iqm_datapath.sv
`default_nettype none

module iqm_datapath #(
   parameter int BLOCK_COEFFS = iqm_pkg::DEFAULT_BLOCK_COEFFS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire iqm_pkg::cmd_type                    cmd,
   output iqm_pkg::status_type                      status,
   input  wire logic [iqm_pkg::DCP_W-1:0]           csr_dc_precision,
   input  wire logic signed [iqm_pkg::COEFF_W-1:0]  req_qf_coeff,
   input  wire logic [iqm_pkg::WEIGHT_W-1:0]        req_weight,
   input  wire logic [iqm_pkg::QSCALE_W-1:0]        req_qscale,
   input  wire logic                                req_intra_mode,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [iqm_pkg::COEFF_W-1:0]       rsp_coeff_out,
   output logic                                     rsp_block_last
);

   localparam int IDX_W  = $clog2(BLOCK_COEFFS);
   localparam int CW     = iqm_pkg::COEFF_W;
   // 2*qf + k reaches -4097 for the most negative qf
   localparam int BASE_W = CW + 2;
   localparam int P1_W   = BASE_W + iqm_pkg::WEIGHT_W + 1;
   localparam int P2_W   = P1_W + iqm_pkg::QSCALE_W + 1;
   localparam int DC_W   = CW + iqm_pkg::DC_SHIFT_MAX;

   logic [iqm_pkg::DCP_W-1:0]  dcp_ff;
   logic [IDX_W-1:0]           idx_ff;
   logic                       parity_ff;
   logic                       valid_ff;

   logic signed [CW-1:0]       qf_ff;
   logic [iqm_pkg::WEIGHT_W-1:0] w_ff;
   logic [iqm_pkg::QSCALE_W-1:0] qs_ff;
   logic                       intra_ff;
   logic                       dc_sel_ff;
   logic signed [P1_W-1:0]     p1_ff;
   logic signed [DC_W-1:0]     dc_ff;
   logic signed [P2_W-1:0]     p2_ff;
   logic signed [CW-1:0]       coeff_ff;
   logic                       last_ff;

   logic signed [BASE_W-1:0]   base;
   logic signed [BASE_W-1:0]   k_val;
   logic [iqm_pkg::DCP_W-1:0]  dc_shift;
   logic signed [P2_W-1:0]     scaled;
   logic signed [P2_W-1:0]     val_wide;
   logic signed [CW-1:0]       sat_val;
   logic                       parity_in;
   logic                       at_last;
   logic signed [CW-1:0]       coeff_in;

   // rounding term: sign of qf for non-intra blocks
   always_comb begin
      if (intra_ff || (qf_ff == '0)) k_val = '0;
      else if (qf_ff[CW-1])          k_val = '1;
      else                           k_val = BASE_W'(1);
      base = (BASE_W'(qf_ff) <<< 1) + k_val;
   end

   assign dc_shift = iqm_pkg::DCP_W'(iqm_pkg::DC_SHIFT_MAX) - dcp_ff;

   // floor shift (or the DC value), then saturate
   always_comb begin
      scaled   = p2_ff >>> iqm_pkg::PROD_SHIFT;
      val_wide = dc_sel_ff ? P2_W'(dc_ff) : scaled;
      if (val_wide > $signed(P2_W'(iqm_pkg::COEFF_MAX)))
         sat_val = CW'(iqm_pkg::COEFF_MAX);
      else if (val_wide < $signed(P2_W'(iqm_pkg::COEFF_MIN)))
         sat_val = CW'(iqm_pkg::COEFF_MIN);
      else
         sat_val = val_wide[CW-1:0];
      parity_in = parity_ff ^ sat_val[0];
      at_last   = (idx_ff == IDX_W'(BLOCK_COEFFS - 1));
      // mismatch control: force odd block sum on the last word
      coeff_in  = (at_last && !parity_in) ? (sat_val ^ CW'(1)) : sat_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dcp_ff    <= '0;
         idx_ff    <= '0;
         parity_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         if (cmd.cfg_write) dcp_ff <= csr_dc_precision;
         if (cmd.finish) begin
            idx_ff    <= at_last ? '0 : idx_ff + IDX_W'(1);
            parity_ff <= at_last ? 1'b0 : parity_in;
            valid_ff  <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         qf_ff     <= req_qf_coeff;
         w_ff      <= req_weight;
         qs_ff     <= req_qscale;
         intra_ff  <= req_intra_mode;
         dc_sel_ff <= req_intra_mode && (idx_ff == '0);
      end
      if (cmd.mul1) begin
         p1_ff <= P1_W'(base * $signed({1'b0, w_ff}));
         dc_ff <= DC_W'(qf_ff) <<< dc_shift;
      end
      if (cmd.mul2) begin
         p2_ff <= P2_W'(p1_ff * $signed({1'b0, qs_ff}));
      end
      if (cmd.finish) begin
         coeff_ff <= coeff_in;
         last_ff  <= at_last;
      end
   end

   assign status.out_full = valid_ff;
   assign rsp_valid       = valid_ff;
   assign rsp_coeff_out   = coeff_ff;
   assign rsp_block_last  = last_ff;

`include "inverse_quantizer_with_mismatch_top_defines.svh"

   `ASSERT_NEXT(a_block_wrap, clock, reset, cmd.finish && at_last,
                (idx_ff == '0) && !parity_ff)
   `ASSERT_NEXT(a_finish_shows, clock, reset, cmd.finish, valid_ff)
   `ASSERT_HOLD(a_one_cmd, clock, reset, $onehot0({cmd.load, cmd.mul1, cmd.mul2, cmd.finish}))

endmodule

`default_nettype wire

// File: sv/inverse_quantizer_with_mismatch_top.sv
// Inverse quantizer with mismatch control for 8x8 transform blocks. Coefficients of a
// block arrive one word at a time in block order, each with its matrix weight,
// quantiser scale and intra flag; each accepted word gives exactly one result word.
// An intra DC coefficient (first of a block with the intra flag set) is scaled by
// 8 >> dc_precision; all others become floor(((2*qf + k) * weight * qscale) / 32)
// with k the sign of qf for non-intra words. Results saturate to -2048..2047 and the
// last word of each block has its lsb flipped when the block sum is even. One word
// is in flight at a time: the sequencer walks accept, two registered multiply steps
// and a shift/saturate (finish) step that registers the result. A finished result
// sits in the output register while the next word is accepted; the finish step
// waits only if that register still holds an untaken word. The user must write
// dc_precision through the csr port while the block is idle; this is not enforced.

`default_nettype none

module inverse_quantizer_with_mismatch_top #(
   parameter int BLOCK_COEFFS = iqm_pkg::DEFAULT_BLOCK_COEFFS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // configuration write
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [iqm_pkg::DCP_W-1:0]           csr_dc_precision,
   // coefficient input
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [iqm_pkg::COEFF_W-1:0]  req_qf_coeff,
   input  wire logic [iqm_pkg::WEIGHT_W-1:0]        req_weight,
   input  wire logic [iqm_pkg::QSCALE_W-1:0]        req_qscale,
   input  wire logic                                req_intra_mode,
   // reconstructed coefficient output
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [iqm_pkg::COEFF_W-1:0]       rsp_coeff_out,
   output logic                                     rsp_block_last
);

   iqm_pkg::cmd_type    cmd;
   iqm_pkg::status_type status;

   // sequencer: handshakes and step order
   iqm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic, block position counter, parity and output register
   iqm_datapath #(
      .BLOCK_COEFFS (BLOCK_COEFFS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_dc_precision (csr_dc_precision),
      .req_qf_coeff     (req_qf_coeff),
      .req_weight       (req_weight),
      .req_qscale       (req_qscale),
      .req_intra_mode   (req_intra_mode),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_coeff_out    (rsp_coeff_out),
      .rsp_block_last   (rsp_block_last)
   );

endmodule

`default_nettype wire
